// File: design/paids_pkg.sv
// Shared types, codes and sizes for the positional array block.
`default_nettype none
package paids_pkg;

  localparam int CAPACITY = 64;
  localparam int POS_W = 7;
  localparam int CMD_W = 3;
  localparam int ST_W = 3;
  localparam int VAL_W = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS,
    OP_DEL,
    OP_UPD,
    OP_SRCH,
    OP_RD
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [POS_W-1:0] found_position;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0] fill_count;
  } out_t;

  typedef struct packed {
    logic vld;
    op_e op;
    logic [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0] cnt;
    logic [POS_W-1:0] found;
    logic signed [VAL_W-1:0] rdata;
  } tok_t;

endpackage
`default_nettype wire

// File: design/paids_cell.sv
// One cell of the entry chain: holds one entry and acts on the passing request token.
`default_nettype none
module paids_cell import paids_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [POS_W-1:0]        cell_pos_i,
  input  wire tok_t                    tok_i,
  input  wire logic signed [VAL_W-1:0] next_entry_i,
  output logic signed [VAL_W-1:0]      entry_o,
  output tok_t                         tok_o
);

  logic signed [VAL_W-1:0] entry_q, entry_d;
  tok_t tok_q, tok_d;
  logic vld_q;

  always_comb begin
    entry_d = entry_q;
    tok_d = tok_i;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        OP_INS: begin
          if (cell_pos_i >= tok_i.pos) begin
            entry_d = tok_i.value;
            tok_d.value = entry_q;
          end
        end
        OP_DEL: begin
          if (cell_pos_i >= tok_i.pos) entry_d = next_entry_i;
        end
        OP_UPD: begin
          if (cell_pos_i == tok_i.pos) entry_d = tok_i.value;
        end
        OP_SRCH: begin
          if ((tok_i.found == '0) && (cell_pos_i <= tok_i.cnt) &&
              (entry_q == tok_i.value)) begin
            tok_d.found = cell_pos_i;
          end
        end
        OP_RD: begin
          if (cell_pos_i == tok_i.pos) tok_d.rdata = entry_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    tok_q <= tok_d;
  end

  assign entry_o = entry_q;

  always_comb begin
    tok_o = tok_q;
    tok_o.vld = vld_q;
  end

endmodule
`default_nettype wire

// File: design/paids_chain.sv
// Row of entry cells; the request token moves one cell per cycle.
`default_nettype none
module paids_chain import paids_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire tok_t tok_i,
  output tok_t      tok_o
);

  tok_t tok [CAPACITY+1];
  logic signed [VAL_W-1:0] ent [CAPACITY];

  assign tok[0] = tok_i;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [VAL_W-1:0] nxt;
    if (k == CAPACITY - 1) begin : g_last
      assign nxt = ent[k];
    end else begin : g_mid
      assign nxt = ent[k+1];
    end
    paids_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_pos_i   (POS_W'(k + 1)),
      .tok_i        (tok[k]),
      .next_entry_i (nxt),
      .entry_o      (ent[k]),
      .tok_o        (tok[k+1])
    );
  end

  assign tok_o = tok[CAPACITY];

endmodule
`default_nettype wire

// File: design/positional_array_insert_delete_search_top.sv
// Top level of the positional array: request checks, fill count, cell chain, result register.
//
//   channel  | direction | handshake                  | payload
//   request  | in        | in_valid_i / in_stall_o    | in_data_i  (cmd, position, value)
//   result   | out       | out_valid_o / out_stall_i  | out_data_o (status, found_position,
//            |           |                            |             read_value, fill_count)
//
// A request passes the chain of CAPACITY cells, one cell per cycle, and then the result
// register; the next request is taken the cycle after that result has been transferred,
// so only one request is in flight at a time.
// Reset clears the fill count and the handshake state; entries stay undefined until written.
// A stalled result holds the block: no request is taken while a result is pending.
`default_nettype none
module positional_array_insert_delete_search_top import paids_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic [POS_W-1:0] count_q, count_d;
  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d;
  logic [ST_W-1:0] status_q, status_d;
  out_t out_q;
  logic accept;
  tok_t tok_in, tok_out;
  logic [POS_W:0] cnt_inc;

  assign in_stall_o = busy_q | out_valid_q;
  assign accept = in_valid_i & ~in_stall_o;
  assign cnt_inc = {1'b0, count_q} + {{POS_W{1'b0}}, 1'b1};

  always_comb begin
    count_d = count_q;
    status_d = status_q;
    tok_in.vld = accept;
    tok_in.op = OP_NONE;
    tok_in.pos = in_data_i.position;
    tok_in.value = in_data_i.value;
    tok_in.cnt = count_q;
    tok_in.found = '0;
    tok_in.rdata = '0;
    if (accept) begin
      status_d = ST_OK;
      unique case (in_data_i.cmd)
        CMD_INSERT: begin
          if (count_q >= POS_W'(CAPACITY)) begin
            status_d = ST_FULL;
          end else if ((in_data_i.position == '0) ||
                       ({1'b0, in_data_i.position} > cnt_inc)) begin
            status_d = ST_BADPOS;
          end else begin
            tok_in.op = OP_INS;
            count_d = cnt_inc[POS_W-1:0];
          end
        end
        CMD_DELETE, CMD_UPDATE, CMD_READ: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else if ((in_data_i.position == '0) || (in_data_i.position > count_q)) begin
            status_d = ST_BADPOS;
          end else begin
            unique case (in_data_i.cmd)
              CMD_DELETE: begin
                tok_in.op = OP_DEL;
                count_d = count_q - POS_W'(1);
              end
              CMD_UPDATE: tok_in.op = OP_UPD;
              default:    tok_in.op = OP_RD;
            endcase
          end
        end
        CMD_SEARCH: tok_in.op = OP_SRCH;
        default: ;
      endcase
    end
  end

  paids_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok_in),
    .tok_o  (tok_out)
  );

  always_comb begin
    busy_d = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (accept) busy_d = 1'b1;
    if (tok_out.vld) begin
      busy_d = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (tok_out.vld) begin
      if (tok_out.op == OP_SRCH) begin
        out_q.status <= (tok_out.found != '0) ? ST_OK : ST_NOTFOUND;
      end else begin
        out_q.status <= status_q;
      end
      out_q.found_position <= tok_out.found;
      out_q.read_value <= tok_out.rdata;
      out_q.fill_count <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= POS_W'(CAPACITY))
    else $error("fill count above capacity");

  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_out.vld |-> busy_q)
    else $error("token left the chain with no request in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("transfer did not start a request");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result appeared without a request");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the positional array block: directed and random requests.
module testbench;
  import paids_pkg::*;

  class array_shadow;
    logic signed [VAL_W-1:0] cells [CAPACITY];
    int count;
    int errors;
    out_t owed_results [$];

    function new();
      count = 0;
      errors = 0;
    endfunction

    function automatic void take_request(in_t req);
      out_t res;
      int pos;
      res = '0;
      pos = int'(req.position);
      case (req.cmd)
        CMD_INSERT: begin
          if (count >= CAPACITY) begin
            res.status = ST_FULL;
          end else if (pos < 1 || pos > count + 1) begin
            res.status = ST_BADPOS;
          end else begin
            for (int i = count; i >= pos; i--) cells[i] = cells[i - 1];
            cells[pos - 1] = req.value;
            count++;
          end
        end
        CMD_DELETE: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else if (pos < 1 || pos > count) begin
            res.status = ST_BADPOS;
          end else begin
            for (int i = pos - 1; i + 1 < count; i++) cells[i] = cells[i + 1];
            count--;
          end
        end
        CMD_UPDATE: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else if (pos < 1 || pos > count) begin
            res.status = ST_BADPOS;
          end else begin
            cells[pos - 1] = req.value;
          end
        end
        CMD_SEARCH: begin
          res.status = ST_NOTFOUND;
          // scan downward so the lowest match wins
          for (int i = count - 1; i >= 0; i--) begin
            if (cells[i] == req.value) begin
              res.status = ST_OK;
              res.found_position = POS_W'(i + 1);
            end
          end
        end
        CMD_READ: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else if (pos < 1 || pos > count) begin
            res.status = ST_BADPOS;
          end else begin
            res.read_value = cells[pos - 1];
          end
        end
        default: begin
        end
      endcase
      res.fill_count = POS_W'(count);
      owed_results.push_back(res);
    endfunction

    function automatic void match_result(out_t got);
      out_t want;
      if (owed_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, got %0d", want.found_position,
               got.found_position);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        errors++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  int in_idle_pct = 20;
  int out_stall_pct = 68;
  array_shadow shadow;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};
  localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_READ + 3'd1;

  positional_array_insert_delete_search_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      shadow.match_result(out_data_o);
    end
  end

  task automatic send_req(input in_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      if ($urandom_range(7) == 0) repeat ($urandom_range(70)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    shadow.take_request(req);
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                          input logic signed [VAL_W-1:0] value);
    in_t req;
    req.cmd = cmd;
    req.position = POS_W'(pos);
    req.value = value;
    send_req(req);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow.owed_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [VAL_W-1:0] held_value();
    if (shadow.count == 0) return VAL_MAX;
    return shadow.cells[$urandom_range(shadow.count - 1)];
  endfunction

  function automatic in_t random_req(int ins_pct, int del_pct);
    in_t req;
    int roll;
    int lim;
    roll = $urandom_range(99);
    if (roll < 4) begin
      req.cmd = CMD_W'($urandom_range(int'(CMD_UNUSED), (1 << CMD_W) - 1));
    end else begin
      roll = $urandom_range(99);
      if (roll < ins_pct) req.cmd = CMD_INSERT;
      else if (roll < ins_pct + del_pct) req.cmd = CMD_DELETE;
      else begin
        case ($urandom_range(2))
          0: req.cmd = CMD_UPDATE;
          1: req.cmd = CMD_SEARCH;
          default: req.cmd = CMD_READ;
        endcase
      end
    end
    lim = (req.cmd == CMD_INSERT) ? shadow.count + 1 : shadow.count;
    roll = $urandom_range(9);
    if (roll < 7 && lim >= 1) req.position = POS_W'($urandom_range(1, lim));
    else if (roll == 7) req.position = POS_W'($urandom_range(1) ? 1 : lim);
    else req.position = POS_W'($urandom_range((1 << POS_W) - 1));
    roll = $urandom_range(9);
    if (req.cmd == CMD_SEARCH && $urandom_range(9) < 6) req.value = held_value();
    else if (roll < 5) req.value = $urandom;
    else if (roll < 8) req.value = VAL_W'($urandom_range(15)) - 8;
    else if (roll == 8) req.value = held_value();
    else req.value = $urandom_range(1) ? VAL_MAX : VAL_MIN;
    return req;
  endfunction

  task automatic run_random(input int n_items);
    int sent;
    int seg;
    int seg_len;
    int ins_pct;
    int del_pct;
    in_t req;
    sent = 0;
    seg = 0;
    while (sent < n_items) begin
      case (seg % 4)
        0: begin ins_pct = 80; del_pct = 5; end
        2: begin ins_pct = 5; del_pct = 80; end
        default: begin ins_pct = 35; del_pct = 25; end
      endcase
      seg_len = $urandom_range(100, 200);
      while (seg_len > 0 && sent < n_items) begin
        req = random_req(ins_pct, del_pct);
        send_req(req);
        if (req.cmd <= CMD_READ) sent++;
        seg_len--;
      end
      seg++;
    end
  endtask

  initial begin
    shadow = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty list, bad positions, ends of the list, extremes, unused commands
    send_cmd(CMD_READ, 1, 0);
    send_cmd(CMD_DELETE, 1, 0);
    send_cmd(CMD_UPDATE, 1, 5);
    send_cmd(CMD_SEARCH, 0, 0);
    send_cmd(CMD_INSERT, 0, 1);
    send_cmd(CMD_INSERT, 2, 1);
    send_cmd(CMD_INSERT, 1, VAL_MIN);
    send_cmd(CMD_INSERT, 2, VAL_MAX);
    send_cmd(CMD_INSERT, 1, -1);
    send_cmd(CMD_INSERT, 2, 0);
    send_cmd(CMD_INSERT, 3, 0);
    send_cmd(CMD_READ, 1, 0);
    send_cmd(CMD_READ, 5, 0);
    send_cmd(CMD_READ, 0, 0);
    send_cmd(CMD_READ, 6, 0);
    send_cmd(CMD_READ, (1 << POS_W) - 1, 0);
    send_cmd(CMD_UPDATE, 5, 32'sh5555_5555);
    send_cmd(CMD_UPDATE, 0, 1);
    send_cmd(CMD_SEARCH, 0, 0);
    send_cmd(CMD_SEARCH, 0, 32'sh1234_5678);
    send_cmd(CMD_DELETE, 1, 0);
    send_cmd(CMD_DELETE, 4, 0);
    send_cmd(CMD_DELETE, 9, 0);
    send_cmd(CMD_UNUSED, (1 << POS_W) - 1, '1);
    send_cmd('1, 1, VAL_MIN);

    run_random(590);
    wait_drained();
    in_idle_pct = 68;
    out_stall_pct = 20;
    run_random(615);
    wait_drained();
    in_idle_pct = 0;
    out_stall_pct = 0;
    run_random(615);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (2 * CAPACITY) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.owed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule
